// ===== rtl/vnorm_pkg.sv =====
// vnorm_pkg: widths, stage counts and queue word types for the vector normalizer.
// Used by every module under rtl; depends on nothing.
package vnorm_pkg;

    localparam int CompW       = 32;
    localparam int UnitFrac    = 30;
    localparam int SqW         = 2 * CompW;
    localparam int SqrtStages  = CompW;
    localparam int DivStages   = UnitFrac + 1;
    localparam int DivW        = CompW + UnitFrac;
    localparam int QueueW      = 4 * CompW + 3;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);

    typedef logic [QueueW-1:0] queue_word_t;

    // Word between the magnitude front and the divide back.
    typedef struct packed {
        logic [2:0][CompW-1:0] mag;
        logic [2:0]            neg;
        logic [CompW-1:0]      len;
    } mid_word_t;

    // Finished result word.
    typedef struct packed {
        logic [2:0][CompW-1:0] unit;
        logic [CompW-1:0]      len;
        logic                  zero;
        logic [1:0]            pad;
    } out_word_t;

endpackage

// ===== rtl/vnorm_fifo.sv =====
// vnorm_fifo: small register queue with push/full and pop/empty sides.
// Depends on vnorm_pkg for the word type and depth.
module vnorm_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  vnorm_pkg::queue_word_t wdata,
    output logic                  full,
    input  logic                  pop,
    output vnorm_pkg::queue_word_t rdata,
    output logic                  empty
);
    import vnorm_pkg::*;

    queue_word_t              mem_reg [QueueDepth];
    logic [QueuePtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QueuePtrW:0]       count_reg, count_next;
    logic                     do_push, do_pop;

    assign full    = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QueuePtrW+1)'(QueueDepth))
        else $error("queue count above depth");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow queue");
    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!full) |-> (QueuePtrW'(wr_ptr_reg - rd_ptr_reg) == QueuePtrW'(count_reg)))
        else $error("pointers disagree with count");

endmodule

// ===== rtl/vnorm_front.sv =====
// vnorm_front: absolute value, squares, sum and bit-per-stage square root.
// Depends on vnorm_pkg.
module vnorm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_vld,
    input  logic [2:0][31:0]       comp,
    output logic                   in_rdy,
    output logic                   out_vld,
    input  logic                   out_rdy,
    output vnorm_pkg::mid_word_t   out_word
);
    import vnorm_pkg::*;

    logic                  en;
    // stage 0: magnitudes
    logic                  v0_reg;
    logic [2:0][CompW-1:0] mag0_reg;
    logic [2:0]            neg0_reg;
    // stage 1: squares
    logic                  v1_reg;
    logic [2:0][CompW-1:0] mag1_reg;
    logic [2:0]            neg1_reg;
    logic [2:0][SqW-1:0]   sq1_reg;
    // stage 2: sum
    logic                  v2_reg;
    logic [2:0][CompW-1:0] mag2_reg;
    logic [2:0]            neg2_reg;
    logic [SqW-1:0]        sum2_reg;
    // root stages
    logic                  rv_reg   [SqrtStages];
    logic [2:0][CompW-1:0] rmag_reg [SqrtStages];
    logic [2:0]            rneg_reg [SqrtStages];
    logic [SqW-1:0]        rrem_reg [SqrtStages];
    logic [CompW-1:0]      rroot_reg[SqrtStages];
    logic [SqW-1:0]        rrem_next [SqrtStages];
    logic [CompW-1:0]      rroot_next[SqrtStages];

    assign en     = !rv_reg[SqrtStages-1] || out_rdy;
    assign in_rdy = en;

    always_comb
    begin
        logic [SqW-1:0]   src_rem;
        logic [CompW-1:0] src_root;
        logic [SqW+1:0]   trial;
        for (int s = 0; s < SqrtStages; s++)
        begin
            src_rem  = (s == 0) ? sum2_reg : rrem_reg[(s == 0) ? 0 : s-1];
            src_root = (s == 0) ? '0 : rroot_reg[(s == 0) ? 0 : s-1];
            trial = ((SqW+2)'(src_root) << (CompW - s))
                  + ((SqW+2)'(1) << (2 * (CompW - 1 - s)));
            if ((SqW+2)'(src_rem) >= trial)
            begin
                rrem_next[s]  = SqW'((SqW+2)'(src_rem) - trial);
                rroot_next[s] = src_root | (CompW'(1) << (CompW - 1 - s));
            end
            else
            begin
                rrem_next[s]  = src_rem;
                rroot_next[s] = src_root;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int s = 0; s < SqrtStages; s++)
            begin
                rv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v0_reg    <= in_vld;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            rv_reg[0] <= v2_reg;
            for (int s = 1; s < SqrtStages; s++)
            begin
                rv_reg[s] <= rv_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                neg0_reg[i] <= comp[i][CompW-1];
                mag0_reg[i] <= comp[i][CompW-1] ? (~comp[i] + 1'b1) : comp[i];
                sq1_reg[i]  <= SqW'(mag0_reg[i]) * SqW'(mag0_reg[i]);
            end
            mag1_reg <= mag0_reg;
            neg1_reg <= neg0_reg;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            sum2_reg <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            rmag_reg[0] <= mag2_reg;
            rneg_reg[0] <= neg2_reg;
            for (int s = 1; s < SqrtStages; s++)
            begin
                rmag_reg[s] <= rmag_reg[s-1];
                rneg_reg[s] <= rneg_reg[s-1];
            end
            for (int s = 0; s < SqrtStages; s++)
            begin
                rrem_reg[s]  <= rrem_next[s];
                rroot_reg[s] <= rroot_next[s];
            end
        end
    end

    assign out_vld      = rv_reg[SqrtStages-1];
    assign out_word.mag = rmag_reg[SqrtStages-1];
    assign out_word.neg = rneg_reg[SqrtStages-1];
    assign out_word.len = rroot_reg[SqrtStages-1];

endmodule

// ===== rtl/vnorm_back.sv =====
// vnorm_back: three-lane restoring divide, one quotient bit per stage, then sign.
// Depends on vnorm_pkg.
module vnorm_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  vnorm_pkg::mid_word_t in_word,
    output logic                 in_rdy,
    output logic                 out_vld,
    input  logic                 out_rdy,
    output vnorm_pkg::out_word_t out_word
);
    import vnorm_pkg::*;

    logic                  en;
    logic                  dv_reg  [DivStages];
    logic [CompW-1:0]      dlen_reg[DivStages];
    logic [2:0]            dneg_reg[DivStages];
    logic [2:0][DivW-1:0]  drem_reg[DivStages];
    logic [2:0][UnitFrac:0] dq_reg [DivStages];
    logic [2:0][DivW-1:0]  drem_next[DivStages];
    logic [2:0][UnitFrac:0] dq_next [DivStages];

    assign en     = !dv_reg[DivStages-1] || out_rdy;
    assign in_rdy = en;

    always_comb
    begin
        logic [DivW-1:0]     src_rem;
        logic [UnitFrac:0]   src_q;
        logic [CompW-1:0]    src_len;
        logic [DivW-1:0]     dsr;
        for (int s = 0; s < DivStages; s++)
        begin
            src_len = (s == 0) ? in_word.len : dlen_reg[(s == 0) ? 0 : s-1];
            dsr     = DivW'(src_len) << (UnitFrac - s);
            for (int i = 0; i < 3; i++)
            begin
                src_rem = (s == 0) ? {in_word.mag[i], UnitFrac'(0)}
                                   : drem_reg[(s == 0) ? 0 : s-1][i];
                src_q   = (s == 0) ? '0 : dq_reg[(s == 0) ? 0 : s-1][i];
                if (src_rem >= dsr)
                begin
                    drem_next[s][i] = src_rem - dsr;
                    dq_next[s][i]   = src_q | ((UnitFrac+1)'(1) << (UnitFrac - s));
                end
                else
                begin
                    drem_next[s][i] = src_rem;
                    dq_next[s][i]   = src_q;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DivStages; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            dv_reg[0] <= in_vld;
            for (int s = 1; s < DivStages; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlen_reg[0] <= in_word.len;
            dneg_reg[0] <= in_word.neg;
            for (int s = 1; s < DivStages; s++)
            begin
                dlen_reg[s] <= dlen_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
            end
            for (int s = 0; s < DivStages; s++)
            begin
                drem_reg[s] <= drem_next[s];
                dq_reg[s]   <= dq_next[s];
            end
        end
    end

    // Apply sign; force zeros when the magnitude is zero.
    always_comb
    begin
        logic [CompW-1:0] q;
        out_word.len  = dlen_reg[DivStages-1];
        out_word.zero = (dlen_reg[DivStages-1] == '0);
        out_word.pad  = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = CompW'(dq_reg[DivStages-1][i]);
            if (out_word.zero)
            begin
                out_word.unit[i] = '0;
            end
            else
            begin
                out_word.unit[i] = dneg_reg[DivStages-1][i] ? (~q + 1'b1) : q;
            end
        end
    end

    assign out_vld = dv_reg[DivStages-1];

endmodule

// ===== rtl/vec3_normalize_unit.sv =====
// vec3_normalize_unit: top level of the 3D vector normalizer.
// Depends on vnorm_pkg, vnorm_front, vnorm_back and vnorm_fifo.
//
// Takes one signed Q16.16 vector per word and returns its truncated magnitude
// (unsigned Q16.16) and the unit vector in signed Q2.30, with zero_vector set and
// all other fields zero for an all-zero input. One word is accepted every clock
// while results are drained. On its way to the output queue a word goes through
// the stages of absolute value, squaring and summing, 32 square-root stages that
// each resolve one root bit, the 4-entry middle queue, and 31 divide stages that
// each resolve one quotient bit on all three components at once. The front
// (magnitude) and back (divide) pipelines each hold while their last stage is
// valid and their downstream queue is full, so the back can stall on a slow
// reader without stopping the front until the middle queue fills.
module vec3_normalize_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] comp_x,
    input  logic [31:0] comp_y,
    input  logic [31:0] comp_z,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] unit_x,
    output logic [31:0] unit_y,
    output logic [31:0] unit_z,
    output logic [31:0] length,
    output logic        zero_vector
);
    import vnorm_pkg::*;

    logic        front_rdy, front_vld;
    mid_word_t   front_word, back_in_word;
    logic        mid_full, mid_empty;
    queue_word_t mid_rdata, out_rdata;
    logic        back_rdy, back_vld;
    out_word_t   back_word, res_word;
    logic        out_full;

    // Accept a word only when the front pipeline advances.
    assign full = !front_rdy;

    vnorm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (push),
        .comp    ({comp_z, comp_y, comp_x}),
        .in_rdy  (front_rdy),
        .out_vld (front_vld),
        .out_rdy (!mid_full),
        .out_word(front_word)
    );

    // Middle queue: decouple magnitude from divide.
    vnorm_fifo u_mid_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (front_vld),
        .wdata(queue_word_t'(front_word)),
        .full (mid_full),
        .pop  (back_rdy),
        .rdata(mid_rdata),
        .empty(mid_empty)
    );

    assign back_in_word = mid_word_t'(mid_rdata);

    vnorm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (!mid_empty),
        .in_word (back_in_word),
        .in_rdy  (back_rdy),
        .out_vld (back_vld),
        .out_rdy (!out_full),
        .out_word(back_word)
    );

    // Output queue: hold finished words until popped.
    vnorm_fifo u_out_q (
        .clk  (clk),
        .rst_n(rst_n),
        .push (back_vld),
        .wdata(queue_word_t'(back_word)),
        .full (out_full),
        .pop  (pop),
        .rdata(out_rdata),
        .empty(empty)
    );

    assign res_word    = out_word_t'(out_rdata);
    assign unit_x      = res_word.unit[0];
    assign unit_y      = res_word.unit[1];
    assign unit_z      = res_word.unit[2];
    assign length      = res_word.len;
    assign zero_vector = res_word.zero;

endmodule
